[src/tet_circumradius_alpha_filter_unit_defines.svh]
// assertion macros for the tetrahedron circumradius filter
// used by the top level only, needs clk and rst in scope
`ifndef TET_CIRCUMRADIUS_ALPHA_FILTER_UNIT_DEFINES_SVH
`define TET_CIRCUMRADIUS_ALPHA_FILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define TCAF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCAF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/tcaf_pkg.sv]
// shared types, constants and the multiply-accumulate program
// for the tetrahedron circumradius filter; no dependencies
package tcaf_pkg;

  localparam int COORD_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int RAM_DEPTH = 23;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  localparam int U_BASE   = 0;
  localparam int V_BASE   = 3;
  localparam int W_BASE   = 6;
  localparam int VW_BASE  = 9;
  localparam int WU_BASE  = 12;
  localparam int UV_BASE  = 15;
  localparam int SQ_BASE  = 18;
  localparam int DEN_ADDR = 21;
  localparam int NUM_ADDR = 22;
  localparam int DIFF_LAST = 8;

  localparam int PROG_LEN = 60;
  localparam int PC_W     = $clog2(PROG_LEN);

  localparam logic REG_ALPHA_LIMIT     = 1'b0;
  localparam logic REG_ALPHA_UNBOUNDED = 1'b1;

  typedef enum logic [1:0] {OP_MAC, OP_STORE, OP_END} op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic              clr;
    logic              sub;
    logic              tgt;
    logic              chk;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] w;
  } op_t;

  typedef op_t [PROG_LEN-1:0] prog_t;

  typedef struct packed {
    logic start;
    logic clr;
    logic sub;
    logic tgt;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIFF, ST_EXEC, ST_LOAD, ST_MUL, ST_ROOT_GO, ST_ROOT, ST_DONE
  } seq_st_t;

  typedef enum logic [1:0] {DV_IDLE, DV_DIV, DV_SQRT} dv_st_t;

  function automatic op_t mk_mac(int a, int b, logic clr, logic sub, logic tgt);
    op_t o;
    o = '0;
    o.kind = OP_MAC;
    o.a = ADDR_W'(a);
    o.b = ADDR_W'(b);
    o.clr = clr;
    o.sub = sub;
    o.tgt = tgt;
    return o;
  endfunction

  function automatic op_t mk_store(int w, logic chk);
    op_t o;
    o = '0;
    o.kind = OP_STORE;
    o.w = ADDR_W'(w);
    o.chk = chk;
    return o;
  endfunction

  function automatic prog_t build_prog();
    prog_t p;
    int n;
    int i;
    int s;
    int j;
    int k;
    p = '0;
    n = 0;
    // cross products vw, wu, uv
    for (i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      k = (i == 0) ? 2 : i - 1;
      p[n] = mk_mac(V_BASE + j, W_BASE + k, 1'b1, 1'b0, 1'b0); n++;
      p[n] = mk_mac(V_BASE + k, W_BASE + j, 1'b0, 1'b1, 1'b0); n++;
      p[n] = mk_store(VW_BASE + i, 1'b0); n++;
      p[n] = mk_mac(W_BASE + j, U_BASE + k, 1'b1, 1'b0, 1'b0); n++;
      p[n] = mk_mac(W_BASE + k, U_BASE + j, 1'b0, 1'b1, 1'b0); n++;
      p[n] = mk_store(WU_BASE + i, 1'b0); n++;
      p[n] = mk_mac(U_BASE + j, V_BASE + k, 1'b1, 1'b0, 1'b0); n++;
      p[n] = mk_mac(U_BASE + k, V_BASE + j, 1'b0, 1'b1, 1'b0); n++;
      p[n] = mk_store(UV_BASE + i, 1'b0); n++;
    end
    // squared lengths
    for (i = 0; i < 3; i++) begin
      for (s = 0; s < 3; s++) begin
        p[n] = mk_mac(U_BASE + 3 * i + s, U_BASE + 3 * i + s, (s == 0), 1'b0, 1'b0);
        n++;
      end
      p[n] = mk_store(SQ_BASE + i, 1'b0); n++;
    end
    // half denominator, zero check
    for (s = 0; s < 3; s++) begin
      p[n] = mk_mac(VW_BASE + s, U_BASE + s, (s == 0), 1'b0, 1'b0); n++;
    end
    p[n] = mk_store(DEN_ADDR, 1'b1); n++;
    // numerator components and their squared sum
    for (i = 0; i < 3; i++) begin
      p[n] = mk_mac(VW_BASE + i, SQ_BASE, 1'b1, 1'b0, 1'b0); n++;
      p[n] = mk_mac(WU_BASE + i, SQ_BASE + 1, 1'b0, 1'b0, 1'b0); n++;
      p[n] = mk_mac(UV_BASE + i, SQ_BASE + 2, 1'b0, 1'b0, 1'b0); n++;
      p[n] = mk_store(NUM_ADDR, 1'b0); n++;
      p[n] = mk_mac(NUM_ADDR, NUM_ADDR, (i == 0), 1'b0, 1'b1); n++;
    end
    p[n] = mk_mac(DEN_ADDR, DEN_ADDR, 1'b1, 1'b0, 1'b0); n++;
    p[n] = '0;
    p[n].kind = OP_END;
    return p;
  endfunction

  localparam prog_t PROG = build_prog();

endpackage

[src/tet_circumradius_alpha_filter_unit.sv]
// tetrahedron circumradius alpha filter, top level; depends on tcaf_pkg,
// tcaf_ram, tcaf_mac, tcaf_divsqrt and the assertion macro header
// one tetrahedron at a time: 9 differences, 59 sequenced ops on the
// radix-4 multiply-accumulate unit (one base-4 digit of the second operand per
// step), then the divide and integer root in the divide/root unit; degenerate
// tets skip from the zero check; next tet accepted once the beat is in the
// output register; synchronous reset clears control and the maximum
`include "tet_circumradius_alpha_filter_unit_defines.svh"

module tet_circumradius_alpha_filter_unit #(
  parameter int COORD_BITS    = tcaf_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = tcaf_pkg::FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [3*COORD_BITS-1:0] vertex_a,
  input  logic [3*COORD_BITS-1:0] vertex_b,
  input  logic [3*COORD_BITS-1:0] vertex_c,
  input  logic [3*COORD_BITS-1:0] vertex_d,
  input  logic                    restart,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [31:0]             radius,
  output logic                    keep,
  output logic                    degenerate,
  output logic                    saturated,
  output logic [31:0]             largest_radius
);
  import tcaf_pkg::*;

  localparam int C       = COORD_BITS;
  localparam int DIFF_W  = C + 1;
  localparam int CROSS_W = 2 * DIFF_W + 1;
  localparam int NUM_W   = 2 * CROSS_W + 2;
  localparam int OPW     = NUM_W;
  localparam int ACC_W   = 2 * OPW + 2;

  seq_st_t st, st_next;

  logic [31:0]       alpha_limit;
  logic              alpha_unbounded;
  logic [31:0]       running_max;
  logic [3*C-1:0]    va, vb, vc, vd;
  logic              restart_l;
  logic              degen;
  logic [PC_W-1:0]   pc;
  logic [ADDR_W-1:0] dcnt;
  logic [1:0]        vsel;
  logic [1:0]        comp;
  op_t               op;

  logic [3*C-1:0]    vsrc;
  logic [C-1:0]      crd, crd_a;
  logic [DIFF_W-1:0] diff;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [OPW-1:0]    ram_wdata;
  logic [OPW-1:0]    rd_a, rd_b;
  mac_ctl_t          mac_ctl;
  logic              mac_busy;
  logic [ACC_W-1:0]  acc0, acc1;
  logic              root_start;
  logic              root_busy;
  logic              root_sat;
  logic [31:0]       root;
  logic [31:0]       rad;
  logic [31:0]       base_max;
  logic [31:0]       max_next;
  logic              out_free;

  assign in_stall = (st != ST_IDLE);
  assign op       = PROG[pc];
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (vsel)
      2'd0:    vsrc = vb;
      2'd1:    vsrc = vc;
      default: vsrc = vd;
    endcase
    unique case (comp)
      2'd0: begin
        crd   = vsrc[C-1:0];
        crd_a = va[C-1:0];
      end
      2'd1: begin
        crd   = vsrc[2*C-1:C];
        crd_a = va[2*C-1:C];
      end
      default: begin
        crd   = vsrc[3*C-1:2*C];
        crd_a = va[3*C-1:2*C];
      end
    endcase
  end

  assign diff = {crd[C-1], crd} - {crd_a[C-1], crd_a};

  always_comb begin
    st_next    = st;
    ram_we     = 1'b0;
    ram_waddr  = dcnt;
    ram_wdata  = {{(OPW-DIFF_W){diff[DIFF_W-1]}}, diff};
    mac_ctl    = '0;
    root_start = 1'b0;
    unique case (st)
      ST_IDLE: if (in_valid) st_next = ST_DIFF;
      ST_DIFF: begin
        ram_we = 1'b1;
        if (dcnt == ADDR_W'(DIFF_LAST)) st_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (op.kind)
          OP_MAC: st_next = ST_LOAD;
          OP_STORE: begin
            ram_we    = 1'b1;
            ram_waddr = op.w;
            ram_wdata = acc0[OPW-1:0];
            if (op.chk && acc0 == '0) st_next = ST_DONE;
          end
          OP_END:  st_next = ST_ROOT_GO;
          default: st_next = ST_DONE;
        endcase
      end
      ST_LOAD: begin
        mac_ctl.start = 1'b1;
        mac_ctl.clr   = op.clr;
        mac_ctl.sub   = op.sub;
        mac_ctl.tgt   = op.tgt;
        st_next       = ST_MUL;
      end
      ST_MUL: if (!mac_busy) st_next = ST_EXEC;
      ST_ROOT_GO: begin
        root_start = 1'b1;
        st_next    = ST_ROOT;
      end
      ST_ROOT: if (!root_busy) st_next = ST_DONE;
      ST_DONE: if (out_free) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  assign rad      = (degen || root_sat) ? '1 : root;
  assign base_max = restart_l ? '0 : running_max;
  assign max_next = (!degen && rad > base_max) ? rad : base_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= ST_IDLE;
      pc              <= '0;
      dcnt            <= '0;
      vsel            <= '0;
      comp            <= '0;
      out_valid       <= 1'b0;
      running_max     <= '0;
      alpha_limit     <= '0;
      alpha_unbounded <= 1'b0;
    end else begin
      st <= st_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ALPHA_LIMIT:     alpha_limit <= cfg_data;
          REG_ALPHA_UNBOUNDED: alpha_unbounded <= cfg_data[0];
        endcase
      end
      if (st == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          pc   <= '0;
          dcnt <= '0;
          vsel <= '0;
          comp <= '0;
        end
        ST_DIFF: begin
          dcnt <= dcnt + 1'b1;
          if (comp == 2'd2) begin
            comp <= '0;
            vsel <= vsel + 2'd1;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        ST_EXEC: if (op.kind == OP_STORE) pc <= pc + 1'b1;
        ST_MUL:  if (!mac_busy) pc <= pc + 1'b1;
        ST_DONE: begin
          if (out_free) begin
            running_max <= max_next;
          end
        end
        default: pc <= pc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_IDLE && in_valid) begin
      va        <= vertex_a;
      vb        <= vertex_b;
      vc        <= vertex_c;
      vd        <= vertex_d;
      restart_l <= restart;
      degen     <= 1'b0;
    end
    if (st == ST_EXEC && op.kind == OP_STORE && op.chk && acc0 == '0) begin
      degen <= 1'b1;
    end
    if (st == ST_DONE && out_free) begin
      radius         <= rad;
      degenerate     <= degen;
      saturated      <= !degen && root_sat;
      keep           <= alpha_unbounded || (!degen && !root_sat && root <= alpha_limit);
      largest_radius <= max_next;
    end
  end

  tcaf_ram #(
    .WIDTH (OPW),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (op.a),
    .raddr_b (op.b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  tcaf_mac #(
    .OPW   (OPW),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .op_a (rd_a),
    .op_b (rd_b),
    .busy (mac_busy),
    .acc0 (acc0),
    .acc1 (acc1)
  );

  tcaf_divsqrt #(
    .ACC_W         (ACC_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divsqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .nsq   (acc1),
    .dsq   (acc0),
    .busy  (root_busy),
    .sat   (root_sat),
    .root  (root)
  );

  `TCAF_ASSERT_IMP(a_degen_ones, out_valid && degenerate, radius == '1 && !saturated, "degen beat")
  `TCAF_ASSERT_IMP(a_max_covers, out_valid && !degenerate, largest_radius >= radius, "max low")
  `TCAF_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, st != ST_IDLE, "idle after beat")

endmodule

[src/tcaf_ram.sv]
// generic single-write, dual-read memory with registered read data
// no dependencies
module tcaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[src/tcaf_mac.sv]
// radix-4 digit-serial signed multiply-accumulate with two accumulators
// depends on tcaf_pkg
module tcaf_mac #(
  parameter int OPW   = 71,
  parameter int ACC_W = 144
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tcaf_pkg::mac_ctl_t       ctl,
  input  logic signed [OPW-1:0]    op_a,
  input  logic signed [OPW-1:0]    op_b,
  output logic                     busy,
  output logic [ACC_W-1:0]         acc0,
  output logic [ACC_W-1:0]         acc1
);
  import tcaf_pkg::*;

  logic             tgt;
  logic             neg;
  logic [ACC_W-1:0] ash;
  logic [OPW-1:0]   mb;
  logic [OPW-1:0]   mag_a;
  logic [OPW-1:0]   mag_b;
  logic [ACC_W-1:0] term;
  logic [ACC_W-1:0] acc_sel;
  logic [ACC_W-1:0] acc_next;

  assign mag_a    = op_a[OPW-1] ? OPW'(-op_a) : OPW'(op_a);
  assign mag_b    = op_b[OPW-1] ? OPW'(-op_b) : OPW'(op_b);
  assign term     = (mb[0] ? ash : '0) + (mb[1] ? (ash << 1) : '0);
  assign acc_sel  = tgt ? acc1 : acc0;
  assign acc_next = neg ? acc_sel - term : acc_sel + term;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
    end else if (busy && mb[OPW-1:2] == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      tgt <= ctl.tgt;
      neg <= op_a[OPW-1] ^ op_b[OPW-1] ^ ctl.sub;
      ash <= ACC_W'(mag_a);
      mb  <= mag_b;
      if (ctl.clr) begin
        if (ctl.tgt) begin
          acc1 <= '0;
        end else begin
          acc0 <= '0;
        end
      end
    end else if (busy) begin
      if (tgt) begin
        acc1 <= acc_next;
      end else begin
        acc0 <= acc_next;
      end
      ash <= ash << 2;
      mb  <= mb >> 2;
    end
  end

endmodule

[src/tcaf_divsqrt.sv]
// bit-serial restoring divide (64 quotient bits) then 32-step integer root
// depends on tcaf_pkg
module tcaf_divsqrt #(
  parameter int ACC_W         = 144,
  parameter int FRACTION_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACC_W-1:0] nsq,
  input  logic [ACC_W-1:0] dsq,
  output logic             busy,
  output logic             sat,
  output logic [31:0]      root
);
  import tcaf_pkg::*;

  localparam int NW    = ACC_W + 2 * FRACTION_BITS;
  localparam int DV_W  = ACC_W + 2;
  localparam int CMP_W = (NW - 64 > DV_W) ? NW - 64 : DV_W;

  dv_st_t st, st_next;

  logic [NW-1:0]   nfull;
  logic [DV_W-1:0] dv_full;
  logic            sat_now;
  logic [DV_W-1:0] rem;
  logic [DV_W-1:0] dv;
  logic [63:0]     nlo;
  logic [63:0]     q;
  logic [5:0]      cnt;
  logic [DV_W:0]   rem2;
  logic            ge;
  logic [63:0]     x;
  logic [63:0]     r;
  logic [63:0]     b;
  logic [63:0]     rb;

  assign nfull   = NW'(nsq) << (2 * FRACTION_BITS);
  assign dv_full = {dsq, 2'b00};
  assign sat_now = CMP_W'(nfull[NW-1:64]) >= CMP_W'(dv_full);
  assign rem2    = {rem, nlo[63]};
  assign ge      = rem2 >= {1'b0, dv};
  assign rb      = r + b;
  assign busy    = (st != DV_IDLE);
  assign root    = r[31:0];

  always_comb begin
    st_next = st;
    unique case (st)
      DV_IDLE: if (start && !sat_now) st_next = DV_DIV;
      DV_DIV:  if (cnt == '0) st_next = DV_SQRT;
      DV_SQRT: if (cnt == '0) st_next = DV_IDLE;
      default: st_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= DV_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st)
      DV_IDLE: begin
        if (start) begin
          sat <= sat_now;
          rem <= DV_W'(nfull[NW-1:64]);
          dv  <= dv_full;
          nlo <= nfull[63:0];
          cnt <= 6'd63;
          r   <= '0;
        end
      end
      DV_DIV: begin
        rem <= ge ? DV_W'(rem2 - {1'b0, dv}) : DV_W'(rem2);
        q   <= {q[62:0], ge};
        nlo <= nlo << 1;
        cnt <= cnt - 6'd1;
        if (cnt == '0) begin
          x   <= {q[62:0], ge};
          r   <= '0;
          b   <= 64'h4000_0000_0000_0000;
          cnt <= 6'd31;
        end
      end
      DV_SQRT: begin
        if (x >= rb) begin
          x <= x - rb;
          r <= (r >> 1) + b;
        end else begin
          r <= r >> 1;
        end
        b   <= b >> 2;
        cnt <= cnt - 6'd1;
      end
      default: cnt <= '0;
    endcase
  end

endmodule

[bench/tet_circumradius_alpha_filter_unit_tb.sv]
// self-checking bench for tet_circumradius_alpha_filter_unit: directed table then
// random tetrahedra, checked against an exact wide-integer radius predictor or,
// for typed rows, the table result; depends on tcaf_pkg and the unit under test
`timescale 1ns / 1ps

module tet_circumradius_alpha_filter_unit_tb;
  import tcaf_pkg::*;

  typedef struct {
    logic [31:0] radius;
    logic        keep;
    logic        degenerate;
    logic        saturated;
    logic [31:0] largest_radius;
  } tet_result_t;

  typedef struct {
    logic [47:0] a, b, c, d;
    logic        restart;
    logic        typed;
    tet_result_t res;
  } tet_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [47:0] vertex_a, vertex_b, vertex_c, vertex_d;
  logic        restart;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] radius;
  logic        keep;
  logic        degenerate;
  logic        saturated;
  logic [31:0] largest_radius;

  tet_circumradius_alpha_filter_unit dut (.*);

  logic [31:0] alpha_limit_q;
  logic        alpha_unbounded_q;
  logic [31:0] peak_radius;
  tet_result_t pending_radii[$];
  tet_row_t    tet_rows[$];
  logic        row_typed;
  tet_result_t row_result;
  int          idle_pct, stall_pct;
  int          beats_in;
  int          errors;
  longint      cycles;
  int          hold_left;
  bit          held;

  localparam int HOLD_AT = 1200;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [47:0] pk(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // exact circumradius of one tet, updates the running peak
  function automatic tet_result_t predict_tet(logic [47:0] pa, logic [47:0] pb,
                                              logic [47:0] pc, logic [47:0] pd,
                                              logic rs);
    tet_result_t t;
    longint u[3], v[3], w[3], vw[3], wu[3], uv[3], u2, v2, w2, den, a0;
    logic signed [255:0] num, nsq, dsq, s2, x1, x2;
    logic [255:0] q;
    int j, k;
    if (rs) peak_radius = 0;
    for (int i = 0; i < 3; i++) begin
      a0 = longint'($signed(pa[16*i +: 16]));
      u[i] = longint'($signed(pb[16*i +: 16])) - a0;
      v[i] = longint'($signed(pc[16*i +: 16])) - a0;
      w[i] = longint'($signed(pd[16*i +: 16])) - a0;
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      vw[i] = v[j] * w[k] - v[k] * w[j];
      wu[i] = w[j] * u[k] - w[k] * u[j];
      uv[i] = u[j] * v[k] - u[k] * v[j];
    end
    u2 = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    v2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    w2 = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
    den = 2 * (u[0] * vw[0] + u[1] * vw[1] + u[2] * vw[2]);
    t.radius = '1;
    t.saturated = 1'b0;
    t.degenerate = (den == 0);
    if (t.degenerate) begin
      t.keep = alpha_unbounded_q;
    end else begin
      nsq = 0;
      for (int i = 0; i < 3; i++) begin
        s2 = u2; x1 = vw[i]; num = s2 * x1;
        s2 = v2; x1 = wu[i]; num = num + s2 * x1;
        s2 = w2; x1 = uv[i]; num = num + s2 * x1;
        nsq = nsq + num * num;
      end
      nsq = nsq <<< 16;
      x2 = den;
      dsq = x2 * x2;
      q = $unsigned(nsq) / $unsigned(dsq);
      t.saturated = (q[255:64] != 0);
      if (!t.saturated) t.radius = 32'(root64(q[63:0]));
      t.keep = alpha_unbounded_q | (!t.saturated && t.radius <= alpha_limit_q);
      if (t.radius > peak_radius) peak_radius = t.radius;
    end
    t.largest_radius = peak_radius;
    return t;
  endfunction

  // beat monitor and checker
  always @(posedge clk) begin
    tet_result_t e;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        e = predict_tet(vertex_a, vertex_b, vertex_c, vertex_d, restart);
        if (row_typed) e = row_result;
        pending_radii.insert(pending_radii.size(), e);
        beats_in++;
      end
      if (out_valid && !out_stall) begin
        if (pending_radii.size() == 0) begin
          $display("%0t unexpected beat radius %h", $time, radius);
          errors++;
        end else begin
          e = pending_radii.pop_front();
          if (radius !== e.radius || keep !== e.keep || degenerate !== e.degenerate ||
              saturated !== e.saturated || largest_radius !== e.largest_radius) begin
            $display("%0t mismatch exp r=%h k=%b d=%b s=%b m=%h got r=%h k=%b d=%b s=%b m=%h",
                     $time, e.radius, e.keep, e.degenerate, e.saturated, e.largest_radius,
                     radius, keep, degenerate, saturated, largest_radius);
            errors++;
          end
        end
      end
    end
  end

  // receiver stalls, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!held && beats_in >= HOLD_AT) begin
      held = 1'b1;
      hold_left = 4000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 40_000_000) begin
      $display("tet_circumradius_alpha_filter_unit_tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_ALPHA_LIMIT) alpha_limit_q = val;
    else alpha_unbounded_q = val[0];
  endtask

  task automatic send_tet(tet_row_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    vertex_a <= r.a;
    vertex_b <= r.b;
    vertex_c <= r.c;
    vertex_d <= r.d;
    restart <= r.restart;
    in_valid <= 1'b1;
    row_typed <= r.typed;
    row_result <= r.res;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_radii.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic tet_row_t random_tet();
    tet_row_t r;
    int m, span, ox, oy, oz;
    r.typed = 1'b0;
    r.restart = ($urandom_range(19) == 0);
    m = $urandom_range(9);
    span = (m == 8) ? 2000 : 64;
    ox = $urandom_range(60000) - 30000;
    oy = $urandom_range(60000) - 30000;
    oz = $urandom_range(60000) - 30000;
    r.a = pk(ox + $urandom_range(2*span) - span, oy + $urandom_range(2*span) - span,
             oz + $urandom_range(2*span) - span);
    r.b = pk(ox + $urandom_range(2*span) - span, oy + $urandom_range(2*span) - span,
             oz + $urandom_range(2*span) - span);
    r.c = pk(ox + $urandom_range(2*span) - span, oy + $urandom_range(2*span) - span,
             oz + $urandom_range(2*span) - span);
    r.d = pk(ox + $urandom_range(2*span) - span, oy + $urandom_range(2*span) - span,
             oz + $urandom_range(2*span) - span);
    if (m == 6) begin
      r.a = 48'({$urandom, $urandom});
      r.b = 48'({$urandom, $urandom});
      r.c = 48'({$urandom, $urandom});
      r.d = 48'({$urandom, $urandom});
    end else if (m == 7) begin
      if ($urandom_range(1)) r.d = r.a;
      else begin
        r.a[47:32] = 16'(oz); r.b[47:32] = 16'(oz);
        r.c[47:32] = 16'(oz); r.d[47:32] = 16'(oz);
      end
    end else if (m == 9) begin
      r.a = pk(-32768, -32768, oz);
      r.b = pk(32767, -32768, oz);
      r.c = pk(ox, 32767, oz);
      r.d = pk(ox / 2, oy / 2, oz + $urandom_range(1, 3));
    end
    return r;
  endfunction

  task automatic add_row(logic [47:0] a, logic [47:0] b, logic [47:0] c, logic [47:0] d,
                         logic rs, logic typed, logic [31:0] lr);
    tet_row_t r;
    r.a = a; r.b = b; r.c = c; r.d = d;
    r.restart = rs;
    r.typed = typed;
    r.res.radius = '1;
    r.res.keep = 1'b0;
    r.res.degenerate = 1'b1;
    r.res.saturated = 1'b0;
    r.res.largest_radius = lr;
    tet_rows.insert(tet_rows.size(), r);
  endtask

  initial begin
    logic [31:0] limits[5];
    logic        unb[5];
    int          idles[4];
    int          stalls[4];
    rst = 1'b1;
    cfg_write = 1'b0; cfg_index = REG_ALPHA_LIMIT; cfg_data = '0;
    in_valid = 1'b0; vertex_a = '0; vertex_b = '0; vertex_c = '0; vertex_d = '0;
    restart = 1'b0;
    alpha_limit_q = '0; alpha_unbounded_q = 1'b0; peak_radius = '0;
    row_typed = 1'b0; idle_pct = 0; stall_pct = 0;
    beats_in = 0; errors = 0; cycles = 0; hold_left = 0; held = 1'b0;
    limits = '{32'd0, 32'd256 * 200, 32'hFFFF_FFFF, $urandom, 32'd0};
    unb = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
    idles = '{0, 46, 0, 29};
    stalls = '{0, 0, 46, 29};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // degenerate rows with known results, then extremes and orientations
    add_row('0, '0, '0, '0, 1'b0, 1'b1, 32'd0);
    add_row('1, '1, '1, '1, 1'b0, 1'b1, 32'd0);
    add_row(pk(-32768, -32768, -32768), pk(-32768, -32768, -32768),
            pk(32767, 32767, 32767), pk(0, 0, 0), 1'b0, 1'b1, 32'd0);
    add_row(pk(0, 0, 0), pk(1, 0, 0), pk(0, 1, 0), pk(0, 0, 1), 1'b0, 1'b0, 0);
    add_row(pk(0, 0, 0), pk(0, 1, 0), pk(1, 0, 0), pk(0, 0, 1), 1'b0, 1'b0, 0);
    add_row(pk(-32768, -32768, -32768), pk(32767, -32768, -32768),
            pk(-32768, 32767, -32768), pk(-32768, -32768, 32767), 1'b0, 1'b0, 0);
    add_row(pk(32767, 32767, 32767), pk(-32768, 32767, 32767),
            pk(32767, -32768, 32767), pk(32767, 32767, -32768), 1'b1, 1'b0, 0);
    add_row(pk(-32768, -32768, 0), pk(32767, -32768, 0), pk(0, 32767, 0),
            pk(0, 0, 1), 1'b0, 1'b0, 0);
    add_row(pk(0, 0, 0), pk(1, 1, 1), pk(2, 2, 2), pk(5, -3, 7), 1'b0, 1'b0, 0);
    add_row(pk(3, 4, 5), pk(4, 4, 5), pk(3, 5, 5), pk(3, 4, 6), 1'b1, 1'b0, 0);
    add_row(pk(100, -200, 300), pk(100, -200, 300), pk(1, 2, 3), pk(9, 9, 9),
            1'b1, 1'b0, 0);
    add_row(pk(-5, -5, -5), pk(20, -5, -5), pk(-5, 20, -5), pk(-5, -5, 20), 1'b0, 1'b0, 0);
    add_row(pk(-1, -1, -1), pk(32767, 0, 0), pk(0, -32768, 0), pk(0, 0, 32767),
            1'b0, 1'b0, 0);

    for (int p = 0; p < 5; p++) begin
      write_reg(REG_ALPHA_LIMIT, limits[p]);
      write_reg(REG_ALPHA_UNBOUNDED, {31'd0, unb[p]});
      idle_pct = idles[p % 4];
      stall_pct = stalls[p % 4];
      if (p == 0) begin
        foreach (tet_rows[i]) send_tet(tet_rows[i]);
        row_typed <= 1'b0;
      end
      for (int n = 0; n < 390; n++) send_tet(random_tet());
      drain();
    end

    repeat (1000) @(posedge clk);
    if (errors == 0 && pending_radii.size() == 0) begin
      $display("tet_circumradius_alpha_filter_unit_tb OK");
    end else begin
      $display("tet_circumradius_alpha_filter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
